// File: rtl/bup_pkg.sv
`default_nettype none

package bup_pkg;

	// Widths fixed by the item and result formats.
	localparam int BYTE_W   = 8;
	localparam int OFFSET_W = 7;
	localparam int COUNT_W  = 3;
	localparam int CFG_AW   = 4;
	localparam int CFG_DW   = 32;

	typedef enum logic [1:0] {
		FUNC_LINE = 2'd0,
		FUNC_READ = 2'd1,
		FUNC_DROP = 2'd2,
		FUNC_NONE = 2'd3
	} bup_func_t;

	typedef enum logic [1:0] {
		REG_START_FLAG  = 2'd0,
		REG_ESCAPE_FLAG = 2'd1,
		REG_ABORT_FLAG  = 2'd2,
		REG_ESCAPE_XOR  = 2'd3
	} bup_reg_t;

	typedef struct packed {
		bup_func_t             func;
		logic [BYTE_W-1:0]     line_byte;
		logic                  line_error;
		logic [OFFSET_W-1:0]   read_offset;
	} bup_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0]     read_byte;
		logic                  read_valid;
		logic [COUNT_W-1:0]    packets_ready;
		logic [OFFSET_W-1:0]   oldest_length;
	} bup_result_t;

	typedef struct packed {
		logic [BYTE_W-1:0] start_flag;
		logic [BYTE_W-1:0] escape_flag;
		logic [BYTE_W-1:0] abort_flag;
		logic [BYTE_W-1:0] escape_xor;
	} bup_cfg_t;

	// Per-item status handed from the packet store to the result register.
	typedef struct packed {
		logic                  read_valid;
		logic [COUNT_W-1:0]    packets_ready;
		logic [OFFSET_W-1:0]   oldest_length;
	} bup_status_t;

	localparam logic [BYTE_W-1:0] START_FLAG_RST  = 8'd126;
	localparam logic [BYTE_W-1:0] ESCAPE_FLAG_RST = 8'd125;
	localparam logic [BYTE_W-1:0] ABORT_FLAG_RST  = 8'd127;
	localparam logic [BYTE_W-1:0] ESCAPE_XOR_RST  = 8'd32;

endpackage

`default_nettype wire

// File: rtl/bup_regs.sv
`default_nettype none

module bup_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [bup_pkg::CFG_AW-1:0] paddr,
	input  wire logic [bup_pkg::CFG_DW-1:0] pwdata,
	output logic      [bup_pkg::CFG_DW-1:0] prdata,
	output logic                            pready,
	output bup_pkg::bup_cfg_t               cfg
);

	import bup_pkg::*;

	bup_cfg_t          cfg_q;
	bup_reg_t          reg_sel;
	logic              wr_en;
	logic [BYTE_W-1:0] rd_val;

	assign reg_sel = bup_reg_t'(paddr[CFG_AW-1:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_flag  <= START_FLAG_RST;
			cfg_q.escape_flag <= ESCAPE_FLAG_RST;
			cfg_q.abort_flag  <= ABORT_FLAG_RST;
			cfg_q.escape_xor  <= ESCAPE_XOR_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_START_FLAG:  cfg_q.start_flag  <= pwdata[BYTE_W-1:0];
				REG_ESCAPE_FLAG: cfg_q.escape_flag <= pwdata[BYTE_W-1:0];
				REG_ABORT_FLAG:  cfg_q.abort_flag  <= pwdata[BYTE_W-1:0];
				REG_ESCAPE_XOR:  cfg_q.escape_xor  <= pwdata[BYTE_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_START_FLAG:  rd_val = cfg_q.start_flag;
			REG_ESCAPE_FLAG: rd_val = cfg_q.escape_flag;
			REG_ABORT_FLAG:  rd_val = cfg_q.abort_flag;
			REG_ESCAPE_XOR:  rd_val = cfg_q.escape_xor;
		endcase
	end

	assign prdata = {{(CFG_DW-BYTE_W){1'b0}}, rd_val};

endmodule

`default_nettype wire

// File: rtl/bup_store.sv
`default_nettype none

module bup_store #(
	parameter int BYTE_DEPTH   = 128,
	parameter int PACKET_SLOTS = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       fire,
	input  wire bup_pkg::bup_item_t         item,
	input  wire bup_pkg::bup_cfg_t          cfg,
	output bup_pkg::bup_status_t            status,
	output logic      [bup_pkg::BYTE_W-1:0] rdata_s2
);

	import bup_pkg::*;

	localparam int PW = $clog2(BYTE_DEPTH);
	localparam int SW = $clog2(PACKET_SLOTS);
	localparam int AW = ((PW > OFFSET_W) ? PW : OFFSET_W) + 1;

	// Byte store: payload only, never cleared.
	logic [BYTE_W-1:0] mem [BYTE_DEPTH];

	// Packet FIFO: start and length of every committed packet.
	logic [PW-1:0] ring_start_q [PACKET_SLOTS];
	logic [PW-1:0] ring_len_q   [PACKET_SLOTS];

	logic [SW-1:0] wslot_q, rslot_q, count_q;
	logic [SW-1:0] wslot_n, rslot_n, count_n;
	logic [SW-1:0] wslot_inc, rslot_inc;
	logic [PW-1:0] cur_start_q, wpos_q, head_start_q, head_len_q;
	logic [PW-1:0] cur_start_n, wpos_n, head_start_n, head_len_n;
	logic          in_frame_q, esc_q, in_frame_n, esc_n;

	logic [PW-1:0]     wpos_inc, head_eff, commit_len, raddr;
	logic [PW:0]       len_diff;
	logic [AW-1:0]     addr_sum;
	logic [BYTE_W-1:0] wdata;
	logic              room, commit, mem_we, read_valid;
	logic              have_packet;

	assign wslot_inc   = (wslot_q == SW'(PACKET_SLOTS - 1)) ? '0 : wslot_q + 1'b1;
	assign rslot_inc   = (rslot_q == SW'(PACKET_SLOTS - 1)) ? '0 : rslot_q + 1'b1;
	assign wpos_inc    = (wpos_q == PW'(BYTE_DEPTH - 1)) ? '0 : wpos_q + 1'b1;
	assign have_packet = (count_q != '0);

	// With nothing waiting the oldest start is the start of the frame in progress.
	assign head_eff = have_packet ? head_start_q : cur_start_q;
	assign room     = (wpos_inc != head_eff);
	assign wdata    = esc_q ? (item.line_byte ^ cfg.escape_xor) : item.line_byte;

	always_comb begin
		len_diff = {1'b0, wpos_q} - {1'b0, cur_start_q};
		if (wpos_q < cur_start_q) begin
			len_diff = len_diff + (PW+1)'(BYTE_DEPTH);
		end
		commit_len = len_diff[PW-1:0];
	end

	// The offset is below the packet length on a valid read, so one subtract wraps it.
	always_comb begin
		addr_sum = AW'(head_start_q) + AW'(item.read_offset);
		if (addr_sum >= AW'(BYTE_DEPTH)) begin
			addr_sum = addr_sum - AW'(BYTE_DEPTH);
		end
		raddr = addr_sum[PW-1:0];
	end

	always_comb begin
		in_frame_n   = in_frame_q;
		esc_n        = esc_q;
		cur_start_n  = cur_start_q;
		wpos_n       = wpos_q;
		wslot_n      = wslot_q;
		rslot_n      = rslot_q;
		count_n      = count_q;
		head_start_n = head_start_q;
		head_len_n   = head_len_q;
		commit       = 1'b0;
		mem_we       = 1'b0;
		read_valid   = 1'b0;
		if (fire) begin
			unique case (item.func)
				FUNC_LINE: begin
					priority if (item.line_error) begin
						in_frame_n = 1'b0;
						esc_n      = 1'b0;
						wpos_n     = cur_start_q;
					end else if (item.line_byte == cfg.start_flag) begin
						in_frame_n = 1'b1;
						esc_n      = 1'b0;
						if (wpos_q != cur_start_q) begin
							if (count_q == SW'(PACKET_SLOTS - 2)) begin
								wpos_n = cur_start_q;
							end else begin
								commit      = 1'b1;
								wslot_n     = wslot_inc;
								count_n     = count_q + 1'b1;
								cur_start_n = wpos_q;
								if (!have_packet) begin
									head_start_n = cur_start_q;
									head_len_n   = commit_len;
								end
							end
						end
					end else if (!in_frame_q) begin
						in_frame_n = 1'b0;
					end else if (item.line_byte == cfg.abort_flag) begin
						in_frame_n = 1'b0;
						esc_n      = 1'b0;
						wpos_n     = cur_start_q;
					end else if (item.line_byte == cfg.escape_flag) begin
						esc_n = 1'b1;
					end else if (room) begin
						mem_we = 1'b1;
						esc_n  = 1'b0;
						wpos_n = wpos_inc;
					end else begin
						in_frame_n = 1'b0;
						esc_n      = 1'b0;
						wpos_n     = cur_start_q;
					end
				end
				FUNC_READ: begin
					read_valid = have_packet && (AW'(item.read_offset) < AW'(head_len_q));
				end
				FUNC_DROP: begin
					if (have_packet) begin
						rslot_n      = rslot_inc;
						count_n      = count_q - 1'b1;
						head_start_n = ring_start_q[rslot_inc];
						head_len_n   = ring_len_q[rslot_inc];
					end
				end
				FUNC_NONE: begin
					read_valid = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		status.read_valid = read_valid;
		if (count_n > SW'(7)) begin
			status.packets_ready = COUNT_W'(7);
		end else begin
			status.packets_ready = COUNT_W'(count_n);
		end
		if (count_n == '0) begin
			status.oldest_length = '0;
		end else if (head_len_n > PW'(127)) begin
			status.oldest_length = OFFSET_W'(127);
		end else begin
			status.oldest_length = OFFSET_W'(head_len_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			esc_q       <= 1'b0;
			cur_start_q <= '0;
			wpos_q      <= '0;
			wslot_q     <= '0;
			rslot_q     <= '0;
			count_q     <= '0;
		end else begin
			in_frame_q  <= in_frame_n;
			esc_q       <= esc_n;
			cur_start_q <= cur_start_n;
			wpos_q      <= wpos_n;
			wslot_q     <= wslot_n;
			rslot_q     <= rslot_n;
			count_q     <= count_n;
		end
	end

	always_ff @(posedge clk) begin
		head_start_q <= head_start_n;
		head_len_q   <= head_len_n;
		if (commit) begin
			ring_start_q[wslot_q] <= cur_start_q;
			ring_len_q[wslot_q]   <= commit_len;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wpos_q] <= wdata;
		end
		if (fire) begin
			rdata_s2 <= mem[raddr];
		end
	end

	logic [SW:0]   slot_sum;
	logic [SW-1:0] wslot_chk;

	always_comb begin
		slot_sum = {1'b0, rslot_q} + {1'b0, count_q};
		if (slot_sum >= (SW+1)'(PACKET_SLOTS)) begin
			slot_sum = slot_sum - (SW+1)'(PACKET_SLOTS);
		end
		wslot_chk = slot_sum[SW-1:0];
	end

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= SW'(PACKET_SLOTS - 2))
		else $error("packet count above the slot limit");

	a_slot_track: assert property (@(posedge clk) disable iff (!arst_n)
		wslot_q == wslot_chk)
		else $error("write slot does not match read slot plus count");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (wpos_q == cur_start_q))
		else $error("bytes held while outside a frame");

	a_esc_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> in_frame_q)
		else $error("escape pending outside a frame");

endmodule

`default_nettype wire

// File: rtl/byte_unstuffing_packet_receiver.sv
`default_nettype none

// Byte-unstuffing packet receiver. Each input item is either a byte from the
// serial line (with its error flag), a host read of one byte of the oldest
// waiting packet, or a host drop of that packet, and every item returns one
// result item with the read byte, the number of waiting packets and the length
// of the oldest one. The block takes one item per clock cycle while the
// result is not stalled; an item passes an input register and a result
// register. The edge that accepts an item loads the input register, and the
// edge that moves it on loads the result register, which a result stall
// can hold back. The read byte comes from the registered read port of the
// byte store, which is loaded together with the result register. The store
// keeps one byte free, and at most PACKET_SLOTS-2 packets wait at a time.
// There is no clearing pass after reset: the store is only read inside
// committed packets. The four flag registers sit at byte addresses 0, 4, 8
// and 12 of the APB port and should be written while the block is idle.
module byte_unstuffing_packet_receiver #(
	parameter int BYTE_DEPTH   = 128,
	parameter int PACKET_SLOTS = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [bup_pkg::CFG_AW-1:0] paddr,
	input  wire logic [bup_pkg::CFG_DW-1:0] pwdata,
	output logic      [bup_pkg::CFG_DW-1:0] prdata,
	output logic                            pready,
	input  wire logic                       item_valid,
	output logic                            item_stall,
	input  wire bup_pkg::bup_item_t         item,
	output logic                            result_valid,
	input  wire logic                       result_stall,
	output bup_pkg::bup_result_t            result
);

	import bup_pkg::*;

	bup_cfg_t          cfg;
	bup_item_t         item_s1;
	logic              valid_s1;
	bup_status_t       status;
	bup_status_t       status_s2;
	logic              valid_s2;
	logic [BYTE_W-1:0] rdata_s2;
	logic              fire;

	// The item in the input register is worked on in the cycle that it moves
	// into the result register; the state update happens at that same edge.
	assign fire       = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !fire;

	bup_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bup_store #(
		.BYTE_DEPTH   (BYTE_DEPTH),
		.PACKET_SLOTS (PACKET_SLOTS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item_s1),
		.cfg      (cfg),
		.status   (status),
		.rdata_s2 (rdata_s2)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// Result register; the read byte joins it from the store's read port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s2 <= status;
		end
	end

	// Store entries outside a packet are never shown: a miss reads as zero.
	assign result_valid           = valid_s2;
	assign result.read_byte       = status_s2.read_valid ? rdata_s2 : '0;
	assign result.read_valid      = status_s2.read_valid;
	assign result.packets_ready   = status_s2.packets_ready;
	assign result.oldest_length   = status_s2.oldest_length;

endmodule

`default_nettype wire
